>>> sv/msr_pkg.sv
// shared types, constants and binomial table builder for the masked subset rank block
`timescale 1ns / 1ps

package msr_pkg;

    localparam int SQUARES         = 64;
    localparam int GROUP           = 8;
    localparam int GROUPS          = SQUARES / GROUP;
    localparam int GRP_W           = $clog2(GROUPS);
    localparam int RANK_W          = 30;
    localparam int COUNT_W         = $clog2(SQUARES + 1);
    localparam int A_W             = $clog2(SQUARES);
    localparam int KMAX            = 16;
    localparam int MAX_PIECES_DEF  = 8;
    localparam int MAX_SQUARES_DEF = 50;

    typedef logic [RANK_W-1:0]               t_rank;
    typedef logic [SQUARES-1:0][RANK_W-1:0] t_column;

    // per-square view of one group of squares during the sweep
    typedef struct packed {
        logic [GROUP-1:0]              hit;
        logic [GROUP-1:0][COUNT_W-1:0] idx;
        logic [GROUP-1:0][A_W-1:0]     below;
    } t_group;

    typedef struct packed {
        logic start;
        logic step;
        logic term;
    } t_lane_ctl;

    typedef struct packed {
        logic [3:0]         piece_count;
        logic [5:0]         square_count;
        logic [COUNT_W-1:0] piece_total;
        logic [COUNT_W-1:0] square_total;
        logic               outside;
    } t_check;

    // column k of the pascal triangle, rows 0..63, kept modulo 2^30
    function automatic t_column binom_column(input int k);
        t_column                  col;
        logic [KMAX:0][RANK_W-1:0] row;
        row    = '0;
        row[0] = RANK_W'(1);
        for (int m = 0; m < SQUARES; m++) begin
            col[m] = row[k];
            for (int i = KMAX; i > 0; i--) begin
                row[i] = row[i] + row[i-1];
            end
        end
        return col;
    endfunction

    function automatic logic [SQUARES-1:0] reverse_mask(input logic [SQUARES-1:0] v);
        logic [SQUARES-1:0] r;
        for (int i = 0; i < SQUARES; i++) begin
            r[i] = v[SQUARES-1-i];
        end
        return r;
    endfunction

endpackage

>>> sv/masked_subset_rank.sv
// top level of the masked subset rank block: sweep sequencer, lanes and merge
`timescale 1ns / 1ps

// Ranks the piece set of an item among its allowed squares in the combinatorial number
// system; command 1 ranks from the highest square down by mirroring both masks on entry.
// One item is in work at a time: the sequencer sweeps the 64 squares eight at a time,
// then registers the lane lookups, then merges and checks; the block is ready again the
// cycle after the result is loaded, so no item is accepted before the last one is through.
// The result waits in an output register while the next item is accepted; a result not
// yet taken only holds the merge of the following item. One lane per possible piece
// (MAX_PIECES) catches its piece's count of lower allowed squares and looks up its
// binomial in a 64-entry constant column; ranks are kept modulo 2^30. Items with wrong
// counts, counts above the limits or pieces outside the allowed squares give error 1,
// rank 0.

module masked_subset_rank #(
    parameter int MAX_PIECES  = msr_pkg::MAX_PIECES_DEF,
    parameter int MAX_SQUARES = msr_pkg::MAX_SQUARES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [63:0] i_piece_mask,
    input  logic [63:0] i_square_mask,
    input  logic [3:0]  i_piece_count,
    input  logic [5:0]  i_square_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [29:0] o_rank_index,
    output logic        o_error
);

    localparam int GROUP = msr_pkg::GROUP;
    localparam int CW    = msr_pkg::COUNT_W;
    localparam int AW    = msr_pkg::A_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_TERM,
        S_MERGE
    } t_state;

    t_state                        r_state;
    logic                          r_out_valid;
    msr_pkg::t_rank                r_rank;
    logic                          r_err;
    logic [msr_pkg::SQUARES-1:0]   r_pcs;
    logic [msr_pkg::SQUARES-1:0]   r_sqs;
    logic [3:0]                    r_pc;
    logic [5:0]                    r_sc;
    logic [msr_pkg::GRP_W-1:0]     r_grp;
    logic [CW-1:0]                 r_pbase;
    logic [CW-1:0]                 r_sbase;
    logic                          r_outside;

    logic [CW-1:0]                 n_pbase;
    logic [CW-1:0]                 n_sbase;
    msr_pkg::t_group               grp;
    msr_pkg::t_lane_ctl            ctl;
    msr_pkg::t_check               chk;
    msr_pkg::t_rank [MAX_PIECES-1:0] terms;
    msr_pkg::t_rank                m_rank;
    logic                          m_err;
    logic                          accept;
    logic                          load;

    assign accept = i_valid && (r_state == S_IDLE);
    assign load   = (r_state == S_MERGE) && (!r_out_valid || i_ready);

    // running piece index and lower allowed-square count across the current group
    always_comb begin
        logic [CW-1:0] pc;
        logic [CW-1:0] sc;
        pc  = r_pbase;
        sc  = r_sbase;
        grp = '0;
        for (int g = 0; g < GROUP; g++) begin
            grp.hit[g]   = r_pcs[g];
            grp.idx[g]   = pc;
            grp.below[g] = sc[AW-1:0];
            pc = pc + CW'(r_pcs[g]);
            sc = sc + CW'(r_sqs[g]);
        end
        n_pbase = pc;
        n_sbase = sc;
    end

    assign ctl.start = accept;
    assign ctl.step  = (r_state == S_SWEEP);
    assign ctl.term  = (r_state == S_TERM);

    assign chk.piece_count  = r_pc;
    assign chk.square_count = r_sc;
    assign chk.piece_total  = r_pbase;
    assign chk.square_total = r_sbase;
    assign chk.outside      = r_outside;

    for (genvar j = 0; j < MAX_PIECES; j++) begin : g_lane
        msr_lane #(
            .LANE_IDX (j)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_grp   (grp),
            .o_term  (terms[j])
        );
    end

    msr_merge #(
        .MAX_PIECES  (MAX_PIECES),
        .MAX_SQUARES (MAX_SQUARES)
    ) u_merge (
        .i_terms (terms),
        .i_chk   (chk),
        .o_rank  (m_rank),
        .o_error (m_err)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (r_grp == msr_pkg::GRP_W'(msr_pkg::GROUPS - 1)) begin
                        r_state <= S_TERM;
                    end
                end
                S_TERM: begin
                    r_state <= S_MERGE;
                end
                S_MERGE: begin
                    if (load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end

        // datapath, no reset needed
        if (accept) begin
            r_pcs     <= i_command ? msr_pkg::reverse_mask(i_piece_mask) : i_piece_mask;
            r_sqs     <= i_command ? msr_pkg::reverse_mask(i_square_mask) : i_square_mask;
            r_pc      <= i_piece_count;
            r_sc      <= i_square_count;
            r_grp     <= '0;
            r_pbase   <= '0;
            r_sbase   <= '0;
            r_outside <= 1'b0;
        end else if (r_state == S_SWEEP) begin
            r_pcs     <= r_pcs >> GROUP;
            r_sqs     <= r_sqs >> GROUP;
            r_grp     <= r_grp + 1'b1;
            r_pbase   <= n_pbase;
            r_sbase   <= n_sbase;
            r_outside <= r_outside | (|(r_pcs[GROUP-1:0] & ~r_sqs[GROUP-1:0]));
        end
        if (load) begin
            r_rank <= m_rank;
            r_err  <= m_err;
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_rank_index = r_rank;
    assign o_error      = r_err;

endmodule

>>> sv/msr_lane.sv
// one rank lane: catches the allowed-square count of its own piece and looks up its binomial
`timescale 1ns / 1ps

module msr_lane #(
    parameter int LANE_IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  msr_pkg::t_lane_ctl i_ctl,
    input  msr_pkg::t_group    i_grp,
    output msr_pkg::t_rank     o_term
);

    localparam msr_pkg::t_column COL = msr_pkg::binom_column(LANE_IDX + 1);
    localparam logic [msr_pkg::COUNT_W-1:0] MY_IDX = msr_pkg::COUNT_W'(LANE_IDX);

    logic                     r_hit;
    logic [msr_pkg::A_W-1:0]  r_a;
    msr_pkg::t_rank           r_term;
    logic                     n_hit;
    logic [msr_pkg::A_W-1:0]  n_a;

    // at most one square of a group holds the piece with this lane's index
    always_comb begin
        n_hit = 1'b0;
        n_a   = '0;
        for (int g = 0; g < msr_pkg::GROUP; g++) begin
            if (i_grp.hit[g] && (i_grp.idx[g] == MY_IDX)) begin
                n_hit = 1'b1;
                n_a   = n_a | i_grp.below[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.start) begin
            r_hit <= 1'b0;
        end else if (i_ctl.step && n_hit) begin
            r_hit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step && n_hit) begin
            r_a <= n_a;
        end
        if (i_ctl.term) begin
            r_term <= r_hit ? COL[r_a] : '0;
        end
    end

    assign o_term = r_term;

endmodule

>>> sv/msr_merge.sv
// merge stage: sums the lane terms and checks the item for consistency
`timescale 1ns / 1ps

module msr_merge #(
    parameter int MAX_PIECES  = msr_pkg::MAX_PIECES_DEF,
    parameter int MAX_SQUARES = msr_pkg::MAX_SQUARES_DEF
) (
    input  msr_pkg::t_rank [MAX_PIECES-1:0] i_terms,
    input  msr_pkg::t_check                 i_chk,
    output msr_pkg::t_rank                  o_rank,
    output logic                            o_error
);

    localparam int CW = msr_pkg::COUNT_W;

    msr_pkg::t_rank   sum;
    logic [CW-1:0]    pc;
    logic [CW-1:0]    sc;
    logic             bad;

    always_comb begin
        sum = '0;
        for (int j = 0; j < MAX_PIECES; j++) begin
            sum = sum + i_terms[j];
        end
    end

    assign pc = CW'(i_chk.piece_count);
    assign sc = CW'(i_chk.square_count);

    assign bad = (pc > CW'(MAX_PIECES)) || (sc > CW'(MAX_SQUARES)) || (pc > sc)
              || (i_chk.piece_total != pc) || (i_chk.square_total != sc)
              || i_chk.outside;

    assign o_rank  = bad ? '0 : sum;
    assign o_error = bad;

endmodule
